// ===== hw/rtl/lcgja_pkg.sv =====
// ----------------------------------------------------------------------------
// LCG jump-ahead package
// Shared widths, register indexes and the command and status structures that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lcgja_pkg;

  // Number of lanes seeded per request.
  localparam int LANES = 16;

  // Lane counter width; at least one bit even for a single lane.
  localparam int LANE_CNT_W = (LANES > 1) ? $clog2(LANES) : 1;

  // Field widths.
  localparam int WORD_W  = 32;
  localparam int SEED_W  = 32;
  localparam int FRAME_W = 16;
  localparam int LANE_W  = 6;

  // Stream payload widths, padded to whole bytes.
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 104;
  localparam int M_PAD_W   = M_TDATA_W - (LANE_W + 3 * WORD_W);

  // Configuration register index.
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MULT = 2'd0,
    CFG_INCR = 2'd1
  } cfg_reg_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXP,
    ST_LANE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                  load;       // capture request, init accumulators
    logic                  exp_step;   // one bit of the binary exponentiation
    logic                  lane_load;  // present a lane and advance the state
    logic [LANE_CNT_W-1:0] lane_idx;   // lane being presented
    logic                  last;       // lane being presented is the final one
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic exp_done;  // no set exponent bits remain
  } status_t;

endpackage

// ===== hw/rtl/lcgja_datapath.sv =====
// ----------------------------------------------------------------------------
// LCG jump-ahead datapath
// Holds the configuration registers, the exponentiation accumulators, the
// lane state and the output payload register.
// ----------------------------------------------------------------------------
module lcgja_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [lcgja_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcgja_pkg::WORD_W-1:0]         cfg_data,
  input  logic [lcgja_pkg::SEED_W-1:0]         seed_value,
  input  logic [lcgja_pkg::FRAME_W-1:0]        frame_length,
  input  lcgja_pkg::cmd_t                      cmd,
  output lcgja_pkg::status_t                   status,
  output logic [lcgja_pkg::LANE_W-1:0]         lane_number,
  output logic [lcgja_pkg::WORD_W-1:0]         lane_state,
  output logic [lcgja_pkg::WORD_W-1:0]         jump_multiplier,
  output logic [lcgja_pkg::WORD_W-1:0]         jump_increment,
  output logic                                 last_lane
);

  logic [lcgja_pkg::WORD_W-1:0]  lcg_multiplier;
  logic [lcgja_pkg::WORD_W-1:0]  lcg_increment;
  logic [lcgja_pkg::FRAME_W-1:0] n_rest;
  logic [lcgja_pkg::WORD_W-1:0]  acc_a;
  logic [lcgja_pkg::WORD_W-1:0]  acc_c;
  logic [lcgja_pkg::WORD_W-1:0]  base_a;
  logic [lcgja_pkg::WORD_W-1:0]  base_c;
  logic [lcgja_pkg::WORD_W-1:0]  lane_x;

  logic [lcgja_pkg::WORD_W-1:0]  acc_a_next;
  logic [lcgja_pkg::WORD_W-1:0]  acc_c_next;
  logic [lcgja_pkg::WORD_W-1:0]  base_a_next;
  logic [lcgja_pkg::WORD_W-1:0]  base_c_next;
  logic [lcgja_pkg::WORD_W-1:0]  lane_x_next;

  // Configuration registers; writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_multiplier <= lcgja_pkg::WORD_W'(1);
      lcg_increment  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lcgja_pkg::CFG_MULT: lcg_multiplier <= cfg_data;
        lcgja_pkg::CFG_INCR: lcg_increment  <= cfg_data;
        default: ;
      endcase
    end
  end

  // One squaring step of the affine map and the conditional accumulate.
  // All products keep the low 32 bits, so arithmetic wraps modulo 2^32.
  always_comb begin
    acc_a_next  = acc_a * base_a;
    acc_c_next  = acc_c * base_a + base_c;
    base_c_next = base_c * (base_a + lcgja_pkg::WORD_W'(1));
    base_a_next = base_a * base_a;
    lane_x_next = lcg_multiplier * lane_x + lcg_increment;
  end

  assign status.exp_done = (n_rest == '0);

  // Exponentiation registers and lane state.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_rest <= frame_length;
      acc_a  <= lcgja_pkg::WORD_W'(1);
      acc_c  <= '0;
      base_a <= lcg_multiplier;
      base_c <= lcg_increment;
      lane_x <= seed_value;
    end else begin
      if (cmd.exp_step) begin
        if (n_rest[0]) begin
          acc_a <= acc_a_next;
          acc_c <= acc_c_next;
        end
        base_a <= base_a_next;
        base_c <= base_c_next;
        n_rest <= n_rest >> 1;
      end
      if (cmd.lane_load) begin
        lane_x <= lane_x_next;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (cmd.lane_load) begin
      lane_number     <= lcgja_pkg::LANE_W'(cmd.lane_idx);
      lane_state      <= lane_x;
      jump_multiplier <= acc_a;
      jump_increment  <= acc_c;
      last_lane       <= cmd.last;
    end
  end

endmodule

// ===== hw/rtl/lcgja_ctrl.sv =====
// ----------------------------------------------------------------------------
// LCG jump-ahead controller
// Sequences request capture, the exponentiation steps and the lane results,
// and owns the valid flag of the output register.
// ----------------------------------------------------------------------------
module lcgja_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output logic                m_tvalid,
  input  logic                m_tready,
  input  lcgja_pkg::status_t  status,
  output lcgja_pkg::cmd_t     cmd
);

  lcgja_pkg::state_t                state;
  lcgja_pkg::state_t                state_next;
  logic [lcgja_pkg::LANE_CNT_W-1:0] lane_cnt;
  logic [lcgja_pkg::LANE_CNT_W-1:0] lane_cnt_next;
  logic                             out_free;
  logic                             is_last;

  assign out_free = !m_tvalid || m_tready;
  assign is_last  = (lane_cnt == lcgja_pkg::LANE_CNT_W'(lcgja_pkg::LANES - 1));

  // State, lane counter and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= lcgja_pkg::ST_IDLE;
      lane_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      lane_cnt <= lane_cnt_next;
      if (cmd.lane_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    lane_cnt_next = lane_cnt;
    s_tready      = 1'b0;
    cmd           = '0;
    cmd.lane_idx  = lane_cnt;
    cmd.last      = is_last;
    unique case (state)
      lcgja_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load      = 1'b1;
          lane_cnt_next = '0;
          state_next    = lcgja_pkg::ST_EXP;
        end
      end
      lcgja_pkg::ST_EXP: begin
        if (status.exp_done) begin
          state_next = lcgja_pkg::ST_LANE;
        end else begin
          cmd.exp_step = 1'b1;
        end
      end
      lcgja_pkg::ST_LANE: begin
        if (out_free) begin
          cmd.lane_load = 1'b1;
          lane_cnt_next = lane_cnt + lcgja_pkg::LANE_CNT_W'(1);
          if (is_last) begin
            state_next = lcgja_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = lcgja_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/lcg_lane_seed_and_jump_ahead.sv =====
// ----------------------------------------------------------------------------
// LCG lane seeding and jump-ahead, modulo 2^32
// Takes a seed and a frame length N and returns one starting state per lane
// together with the N-step jump-ahead pair of the generator x = a*x + c.
//
// Usage:
//   Input stream: one transaction carries seed_value and frame_length.
//   Output stream: 16 transactions follow, one per lane in lane order; the
//   final lane is marked by m_tlast. Each carries the lane state and the
//   jump pair (a^N, accumulated increment).
//   Configuration: cfg_we writes cfg_data to register cfg_index
//   (0 = multiplier, 1 = increment) while no request is in flight.
//   Sequence: after the input transaction the exponentiation takes one step
//   per bit of N up to its highest set bit, then one lane is loaded per
//   cycle while the output register is free. The exponentiation loop, four
//   32-bit multipliers updated once per cycle, sets the length of the first
//   part; the single lane multiply-add sets the length of the second.
//   A new request is accepted once the final lane sits in the output
//   register, even while it still waits to be taken.
//   Reset: multiplier returns to 1, increment to 0, no output is valid.
//   Stalls: while a held result waits with m_tready low the output register
//   holds and lane generation pauses; nothing is dropped.
// ----------------------------------------------------------------------------
module lcg_lane_seed_and_jump_ahead (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // s_tdata: seed_value[31:0], frame_length[47:32]
  input  logic [lcgja_pkg::S_TDATA_W-1:0]       s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // m_tdata: lane_number[5:0], lane_state[37:6], jump_multiplier[69:38],
  //          jump_increment[101:70], zero pad[103:102]
  output logic [lcgja_pkg::M_TDATA_W-1:0]       m_tdata,
  output logic                                  m_tlast,
  input  logic                                  cfg_we,
  input  logic [lcgja_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [lcgja_pkg::WORD_W-1:0]          cfg_data
);

  lcgja_pkg::cmd_t                  cmd;
  lcgja_pkg::status_t               status;
  logic [lcgja_pkg::LANE_W-1:0]     lane_number;
  logic [lcgja_pkg::WORD_W-1:0]     lane_state;
  logic [lcgja_pkg::WORD_W-1:0]     jump_multiplier;
  logic [lcgja_pkg::WORD_W-1:0]     jump_increment;

  // Sequencer.
  lcgja_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Arithmetic and storage.
  lcgja_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .seed_value      (s_tdata[lcgja_pkg::SEED_W-1:0]),
    .frame_length    (s_tdata[lcgja_pkg::SEED_W +: lcgja_pkg::FRAME_W]),
    .cmd             (cmd),
    .status          (status),
    .lane_number     (lane_number),
    .lane_state      (lane_state),
    .jump_multiplier (jump_multiplier),
    .jump_increment  (jump_increment),
    .last_lane       (m_tlast)
  );

  // Pack the output payload.
  assign m_tdata = {{lcgja_pkg::M_PAD_W{1'b0}}, jump_increment, jump_multiplier,
                    lane_state, lane_number};

  // The final lane always carries the highest lane number.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> lane_number == lcgja_pkg::LANE_W'(lcgja_pkg::LANES - 1))
    else $error("final lane carries wrong lane number");

  // A lane is never loaded over a result that is still stalled.
  assert property (@(posedge clk) disable iff (rst)
    cmd.lane_load |-> (!m_tvalid || m_tready))
    else $error("output register overwritten while stalled");

  // A request is taken only from the idle state, so input closes right after.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request accepted while one is in flight");

  // Exponent steps never overlap lane generation.
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.exp_step && cmd.lane_load))
    else $error("exponent step and lane load in the same cycle");

endmodule

// ===== tb/sv/tb_lcg_lane_seed_and_jump_ahead.sv =====
// ----------------------------------------------------------------------------
// Testbench for the LCG lane seeding and jump-ahead block
// Sends seed and frame-length requests and predicts the sixteen lane results
// of each one in the bench itself. Every lane result that comes back is
// compared field by field with the oldest prediction. A short table of
// directed requests opens the run, with the jump pair typed in where it is
// obvious. Several random register settings follow, with random idling on
// both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_lcg_lane_seed_and_jump_ahead;

  localparam int RESET_CYCLES    = 9;
  localparam int SETTLE_CYCLES   = 4;
  localparam int DRAIN_CYCLES    = 64;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int DIRECTED_ROWS   = 32;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 58;
  localparam int HOLD_PHASE      = 2;
  localparam int STEADY_PHASE    = 4;

  // Field positions in the output tdata word.
  localparam int STATE_LO = lcgja_pkg::LANE_W;
  localparam int JMUL_LO  = lcgja_pkg::LANE_W + lcgja_pkg::WORD_W;
  localparam int JINC_LO  = lcgja_pkg::LANE_W + 2 * lcgja_pkg::WORD_W;
  localparam int PAD_LO   = lcgja_pkg::LANE_W + 3 * lcgja_pkg::WORD_W;

  // Register indexes past the end of the register list; writes are dropped.
  localparam logic [lcgja_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [lcgja_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // An affine map x -> mul*x + inc, modulo 2^32.
  typedef struct packed {
    logic [lcgja_pkg::WORD_W-1:0] mul;
    logic [lcgja_pkg::WORD_W-1:0] inc;
  } affine_t;

  typedef struct packed {
    logic [lcgja_pkg::LANE_W-1:0] lane;
    logic [lcgja_pkg::WORD_W-1:0] state;
    logic [lcgja_pkg::WORD_W-1:0] jmul;
    logic [lcgja_pkg::WORD_W-1:0] jinc;
    logic                         last;
  } lane_result_t;

  typedef enum logic {ROW_WRITE, ROW_REQUEST} row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [lcgja_pkg::CFG_IDX_W-1:0] index;
    logic [lcgja_pkg::WORD_W-1:0]    value;
    logic [lcgja_pkg::SEED_W-1:0]    seed;
    logic [lcgja_pkg::FRAME_W-1:0]   frame;
    logic                            typed;  // jump pair below is known by hand
    affine_t                         pair;
  } directed_row_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_tvalid = 1'b0;
  logic                              s_tready;
  // s_tdata: seed_value[31:0], frame_length[47:32]
  logic [lcgja_pkg::S_TDATA_W-1:0]   s_tdata = '0;
  logic                              m_tvalid;
  logic                              m_tready = 1'b0;
  // m_tdata: lane_number[5:0], lane_state[37:6], jump_multiplier[69:38],
  //          jump_increment[101:70], zero pad[103:102]
  logic [lcgja_pkg::M_TDATA_W-1:0]   m_tdata;
  logic                              m_tlast;
  logic                              cfg_we = 1'b0;
  logic [lcgja_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [lcgja_pkg::WORD_W-1:0]      cfg_data = '0;

  // Bench copy of the generator registers.
  logic [lcgja_pkg::WORD_W-1:0] lcg_mult = 32'd1;
  logic [lcgja_pkg::WORD_W-1:0] lcg_incr = 32'd0;

  lane_result_t lane_q[$];
  int           mismatches = 0;
  int unsigned  cycle_count = 0;
  bit           pacing_on = 1'b1;
  bit           hold_off_req = 1'b0;

  lcg_lane_seed_and_jump_ahead u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("lcg_lane_seed_and_jump_ahead regression: fail");
      $finish;
    end
  end

  // N-fold composition of x -> a*x + c by square-and-multiply over the bits
  // of N. Composing g after f gives mul = g.mul*f.mul, inc = g.mul*f.inc+g.inc.
  function automatic affine_t jump_ahead(input logic [lcgja_pkg::FRAME_W-1:0] n);
    affine_t acc;
    affine_t sq;
    acc.mul = 32'd1;
    acc.inc = 32'd0;
    sq.mul  = lcg_mult;
    sq.inc  = lcg_incr;
    for (int b = 0; b < lcgja_pkg::FRAME_W; b++) begin
      if (n[b]) begin
        acc.inc = sq.mul * acc.inc + sq.inc;
        acc.mul = sq.mul * acc.mul;
      end
      sq.inc = sq.inc * (sq.mul + 32'd1);
      sq.mul = sq.mul * sq.mul;
    end
    return acc;
  endfunction

  // Queue the lane results of one accepted request.
  task automatic queue_lanes(input logic [lcgja_pkg::SEED_W-1:0]  seed,
                             input logic [lcgja_pkg::FRAME_W-1:0] frame,
                             input logic typed, input affine_t typed_pair);
    affine_t                      pair;
    lane_result_t                 r;
    logic [lcgja_pkg::WORD_W-1:0] x;
    pair = typed ? typed_pair : jump_ahead(frame);
    x = seed;
    for (int k = 0; k < lcgja_pkg::LANES; k++) begin
      r.lane  = k[lcgja_pkg::LANE_W-1:0];
      r.state = x;
      r.jmul  = pair.mul;
      r.jinc  = pair.inc;
      r.last  = (k == lcgja_pkg::LANES - 1);
      lane_q.push_back(r);
      x = lcg_mult * x + lcg_incr;
    end
  endtask

  // Offer one request, optionally after an idle burst, and wait until it is
  // taken. Valid stays high on return so that a following request can go
  // out back to back.
  task automatic send_request(input logic [lcgja_pkg::SEED_W-1:0]  seed,
                              input logic [lcgja_pkg::FRAME_W-1:0] frame,
                              input logic typed, input affine_t typed_pair);
    if (pacing_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {frame, seed};
    do @(posedge clk); while (!s_tready);
    queue_lanes(seed, frame, typed, typed_pair);
  endtask

  // Register writes happen only with nothing in flight.
  task automatic write_register(input logic [lcgja_pkg::CFG_IDX_W-1:0] idx,
                                input logic [lcgja_pkg::WORD_W-1:0]    value);
    s_tvalid <= 1'b0;
    while (lane_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      lcgja_pkg::CFG_MULT: lcg_mult = value;
      lcgja_pkg::CFG_INCR: lcg_incr = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic directed_row_t row_write(input logic [lcgja_pkg::CFG_IDX_W-1:0] idx,
                                              input logic [lcgja_pkg::WORD_W-1:0] value);
    directed_row_t row;
    row       = '0;
    row.kind  = ROW_WRITE;
    row.index = idx;
    row.value = value;
    return row;
  endfunction

  function automatic directed_row_t row_req(input logic [lcgja_pkg::SEED_W-1:0] seed,
                                            input logic [lcgja_pkg::FRAME_W-1:0] frame);
    directed_row_t row;
    row       = '0;
    row.kind  = ROW_REQUEST;
    row.seed  = seed;
    row.frame = frame;
    return row;
  endfunction

  function automatic directed_row_t row_pair(input logic [lcgja_pkg::SEED_W-1:0] seed,
                                             input logic [lcgja_pkg::FRAME_W-1:0] frame,
                                             input logic [lcgja_pkg::WORD_W-1:0] mul,
                                             input logic [lcgja_pkg::WORD_W-1:0] inc);
    directed_row_t row;
    row          = row_req(seed, frame);
    row.typed    = 1'b1;
    row.pair.mul = mul;
    row.pair.inc = inc;
    return row;
  endfunction

  // Random register values, with the extremes showing up often.
  function automatic logic [lcgja_pkg::WORD_W-1:0] pick_word();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'h0000_0001;
      2: return 32'hFFFF_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic void compare_field(input string name,
                                        input logic [lcgja_pkg::WORD_W-1:0] want,
                                        input logic [lcgja_pkg::WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Output pacing: random stall bursts, a long hold-off on request, and a
  // steady ready whenever pacing is off.
  initial begin : sink_pacing
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (pacing_on && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Check every output transaction against the oldest queued lane result.
  always @(posedge clk) begin : lane_checker
    lane_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (lane_q.size() == 0) begin
        $display("%0t: unexpected lane result, expected none, actual tdata %h last %b",
                 $time, m_tdata, m_tlast);
        mismatches++;
      end else begin
        want = lane_q.pop_front();
        compare_field("lane_number", lcgja_pkg::WORD_W'(want.lane),
                      lcgja_pkg::WORD_W'(m_tdata[lcgja_pkg::LANE_W-1:0]));
        compare_field("lane_state", want.state, m_tdata[STATE_LO +: lcgja_pkg::WORD_W]);
        compare_field("jump_multiplier", want.jmul, m_tdata[JMUL_LO +: lcgja_pkg::WORD_W]);
        compare_field("jump_increment", want.jinc, m_tdata[JINC_LO +: lcgja_pkg::WORD_W]);
        compare_field("pad", '0,
                      lcgja_pkg::WORD_W'(m_tdata[PAD_LO +: lcgja_pkg::M_PAD_W]));
        compare_field("last_lane", lcgja_pkg::WORD_W'(want.last),
                      lcgja_pkg::WORD_W'(m_tlast));
      end
    end
  end

  initial begin : stimulus
    directed_row_t                 plan [DIRECTED_ROWS];
    logic [lcgja_pkg::SEED_W-1:0]  seed;
    logic [lcgja_pkg::FRAME_W-1:0] frame;

    // Directed requests. With a multiplier of one the jump pair is (1, c*N);
    // a multiplier of all ones flips sign, so the pair only depends on the
    // parity of N; a zero multiplier collapses every nonzero N to (0, c).
    plan = '{
      row_pair(32'h0000_0000, 16'h0000, 32'd1, 32'd0),
      row_pair(32'hFFFF_FFFF, 16'hFFFF, 32'd1, 32'd0),
      row_pair(32'h1234_5678, 16'h0001, 32'd1, 32'd0),
      row_write(lcgja_pkg::CFG_INCR, 32'd5),
      row_pair(32'h0000_0000, 16'h0000, 32'd1, 32'd0),
      row_pair(32'h0000_0001, 16'd1000, 32'd1, 32'd5000),
      row_pair(32'hFFFF_FFFF, 16'hFFFF, 32'd1, 32'd327675),
      row_write(lcgja_pkg::CFG_MULT, 32'hFFFF_FFFF),
      row_write(lcgja_pkg::CFG_INCR, 32'hFFFF_FFFF),
      row_pair(32'h0000_0000, 16'h0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      row_pair(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      row_pair(32'h8000_0000, 16'hFFFE, 32'd1, 32'd0),
      row_pair(32'h0000_0005, 16'h0000, 32'd1, 32'd0),
      row_write(lcgja_pkg::CFG_MULT, 32'd0),
      row_write(lcgja_pkg::CFG_INCR, 32'd0),
      row_pair(32'hAAAA_AAAA, 16'h0001, 32'd0, 32'd0),
      row_pair(32'h5555_5555, 16'h8000, 32'd0, 32'd0),
      row_write(lcgja_pkg::CFG_INCR, 32'd7),
      row_pair(32'hDEAD_BEEF, 16'h0003, 32'd0, 32'd7),
      // Writes to indexes past the register list must leave (0, 7) alone.
      row_write(CFG_SPARE_LO, 32'hFFFF_FFFF),
      row_write(CFG_SPARE_HI, 32'h0000_0001),
      row_pair(32'h0000_0001, 16'h0002, 32'd0, 32'd7),
      row_write(lcgja_pkg::CFG_MULT, 32'd1664525),
      row_write(lcgja_pkg::CFG_INCR, 32'd1013904223),
      row_req(32'h0000_0000, 16'h0001),
      row_req(32'hFFFF_FFFF, 16'h8000),
      row_req(32'h1234_5678, 16'hFFFF),
      row_pair(32'h0000_0000, 16'h0000, 32'd1, 32'd0),
      row_write(lcgja_pkg::CFG_MULT, 32'h8000_0000),
      row_write(lcgja_pkg::CFG_INCR, 32'd1),
      row_req(32'h0000_0001, 16'h0002),
      row_req(32'hFFFF_FFFF, 16'h0001)
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        write_register(plan[i].index, plan[i].value);
      end else begin
        send_request(plan[i].seed, plan[i].frame, plan[i].typed, plan[i].pair);
      end
    end

    // Random phases, each under a fresh register setting. One phase holds
    // the output off for a long stretch; the middle and final phases run
    // without idling.
    for (int p = 0; p < PHASES; p++) begin
      pacing_on = (p != STEADY_PHASE) && (p != PHASES - 1);
      write_register(lcgja_pkg::CFG_MULT, pick_word());
      write_register(lcgja_pkg::CFG_INCR, pick_word());
      if (p == HOLD_PHASE) hold_off_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        seed = pick_word();
        case ($urandom_range(0, 7))
          0: frame = 16'h0000;
          1: frame = 16'hFFFF;
          2: frame = 16'h0001 << $urandom_range(0, lcgja_pkg::FRAME_W - 1);
          3: frame = lcgja_pkg::FRAME_W'($urandom_range(1, 15));
          default: frame = lcgja_pkg::FRAME_W'($urandom_range(0, 16'hFFFF));
        endcase
        send_request(seed, frame, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (lane_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("lcg_lane_seed_and_jump_ahead regression: pass");
    end else begin
      $display("lcg_lane_seed_and_jump_ahead regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lcgja_pkg.sv
hw/rtl/lcgja_datapath.sv
hw/rtl/lcgja_ctrl.sv
hw/rtl/lcg_lane_seed_and_jump_ahead.sv
tb/sv/tb_lcg_lane_seed_and_jump_ahead.sv
